// ===== rtl/core/ttm_pkg.sv =====
// Shared types, codes and constants of the touch to MIDI converter.
package ttm_pkg;

  localparam int TTM_SLOTS = 16;

  localparam int SID_W  = 32;
  localparam int GRP_W  = 16;
  localparam int TIME_W = 32;
  localparam int POS_W  = 16;
  localparam int KEY_W  = 16;
  localparam int NOTE_W = 7;
  localparam int BEND_W = 14;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 2;

  localparam int BEND_SHIFT = 13;
  localparam int DIV_STEPS  = 30;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
  localparam logic [7:0] STATUS_BEND     = 8'he0;
  localparam logic [7:0] STATUS_CTRL     = 8'hb0;

  localparam logic [NOTE_W-1:0] FINE_CTRL_BIT = 7'h20;
  localparam logic [NOTE_W-1:0] VELOCITY      = 7'h7f;
  localparam logic [NOTE_W-1:0] NOTE_MAX      = 7'h7f;
  localparam logic signed [31:0] BEND_CENTER  = 32'sh1fff;
  localparam logic signed [31:0] BEND_MAX     = 32'sh3fff;

  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_KEY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SPAN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_NUMBER  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FINE_ENABLE  = 2'd3;

  localparam logic [KEY_W-1:0]  RST_BOTTOM_KEY  = 16'd5931;
  localparam logic [KEY_W-1:0]  RST_KEY_SPAN    = 16'd10923;
  localparam logic [NOTE_W-1:0] RST_CTRL_NUMBER = 7'd7;
  localparam logic              RST_FINE_ENABLE = 1'b1;

  typedef enum logic [1:0] {
    CMD_ON   = 2'd0,
    CMD_OFF  = 2'd1,
    CMD_MOVE = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    MSG_ON,
    MSG_OFF,
    MSG_BEND,
    MSG_FINE,
    MSG_COARSE
  } msg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_DECIDE,
    S_DIV_INIT,
    S_DIV,
    S_FIX,
    S_EMIT_ON,
    S_EMIT_BEND,
    S_EMIT_FINE,
    S_EMIT_COARSE,
    S_EMIT_OFF
  } state_t;

  typedef struct packed {
    logic latch;
    logic scan_rd;
    logic load_note;
    logic div_init;
    logic div_step;
    logic fix;
    logic store_slot;
    logic free_slot;
    logic emit;
    msg_t emit_kind;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic hit;
    logic scan_last;
    logic div_last;
    logic fine_en;
  } sts_t;

endpackage

// ===== rtl/core/ttm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ttm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ttm_ctrl.sv =====
// Sequencer of the touch to MIDI converter: scan, divide and message emission.
module ttm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ttm_pkg::sts_t st,
  output ttm_pkg::ctl_t ctl
);
  import ttm_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    ctl.emit_kind = MSG_ON;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.latch = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.scan_rd = 1'b1;
        if (st.scan_last) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        unique case (st.cmd)
          CMD_ON: begin
            ctl.load_note = 1'b1;
            state_nxt = S_DIV_INIT;
          end
          CMD_OFF: begin
            state_nxt = st.hit ? S_EMIT_OFF : S_IDLE;
          end
          CMD_MOVE: begin
            state_nxt = st.hit ? S_DIV_INIT : S_IDLE;
          end
          CMD_NONE: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_DIV_INIT: begin
        ctl.div_init = 1'b1;
        ctl.store_slot = (st.cmd == CMD_ON);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        ctl.fix = 1'b1;
        state_nxt = (st.cmd == CMD_ON) ? S_EMIT_ON : S_EMIT_BEND;
      end
      S_EMIT_ON: begin
        ctl.emit = 1'b1;
        ctl.emit_kind = MSG_ON;
        state_nxt = S_EMIT_BEND;
      end
      S_EMIT_BEND: begin
        ctl.emit = 1'b1;
        ctl.emit_kind = MSG_BEND;
        state_nxt = st.fine_en ? S_EMIT_FINE : S_EMIT_COARSE;
      end
      S_EMIT_FINE: begin
        ctl.emit = 1'b1;
        ctl.emit_kind = MSG_FINE;
        state_nxt = S_EMIT_COARSE;
      end
      S_EMIT_COARSE: begin
        ctl.emit = 1'b1;
        ctl.emit_kind = MSG_COARSE;
        state_nxt = S_IDLE;
      end
      S_EMIT_OFF: begin
        ctl.emit = 1'b1;
        ctl.emit_kind = MSG_OFF;
        ctl.free_slot = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  a_off_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_OFF) |-> st.hit)
    else $error("note-off emitted without a matching session");

  a_div_only_motion: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (st.cmd == CMD_ON || st.cmd == CMD_MOVE))
    else $error("bend division run for an event without motion");

endmodule

// ===== rtl/core/ttm_dp.sv =====
// Datapath of the touch to MIDI converter: session table, key math and divider.
module ttm_dp #(
  parameter int SLOTS = ttm_pkg::TTM_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ttm_pkg::ctl_t                   ctl,
  output ttm_pkg::sts_t                   st,
  input  logic                            cfg_we,
  input  logic [ttm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ttm_pkg::CFG_W-1:0]       cfg_data,
  input  logic [1:0]                      in_cmd,
  input  logic [ttm_pkg::SID_W-1:0]       in_session_id,
  input  logic [ttm_pkg::GRP_W-1:0]       in_group_id,
  input  logic [ttm_pkg::TIME_W-1:0]      in_frame_time,
  input  logic [ttm_pkg::POS_W-1:0]       in_pos_x,
  input  logic [ttm_pkg::POS_W-1:0]       in_pos_y,
  output logic                            out_strobe,
  output logic [ttm_pkg::TIME_W-1:0]      out_time,
  output logic [ttm_pkg::GRP_W-1:0]       out_group,
  output logic [7:0]                      out_status_byte,
  output logic [ttm_pkg::NOTE_W-1:0]      out_data_one,
  output logic [ttm_pkg::NOTE_W-1:0]      out_data_two,
  output logic                            out_last_message
);
  import ttm_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Configuration registers.
  logic [KEY_W-1:0]  bottom_r;
  logic [KEY_W-1:0]  span_r;
  logic [NOTE_W-1:0] ctrl_num_r;
  logic              fine_r;

  // Event registers.
  cmd_t              cmd_r;
  logic [SID_W-1:0]  sid_r;
  logic [GRP_W-1:0]  grp_r;
  logic [TIME_W-1:0] time_r;
  logic [POS_W-1:0]  x_r;
  logic [POS_W-1:0]  y_r;

  // Table scan.
  logic [SLOTS-1:0]  valid_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic              cmp_v_r;
  logic              hit_r;
  logic              free_r;
  logic [SID_W-1:0]  rd_sid;
  logic [NOTE_W-1:0] rd_note;
  logic              ram_we;
  logic              cmp_valid;

  // Arithmetic.
  logic [31:0]             prod_r;
  logic [BEND_W-1:0]       eff_r;
  logic [29:0]             eff_full;
  logic [NOTE_W-1:0]       note_r;
  logic signed [17:0]      key;
  logic [NOTE_W-1:0]       note_on;
  logic signed [18:0]      diff;
  logic [18:0]             diff_neg;
  logic [16:0]             mag;
  logic [KEY_W-1:0]        span_eff;
  logic [DIV_STEPS-1:0]    quo_r;
  logic [KEY_W-1:0]        rem_r;
  logic                    neg_r;
  logic [DIV_CNT_W-1:0]    cnt_r;
  logic [KEY_W:0]          rem_sh;
  logic                    rem_ge;
  logic [KEY_W:0]          rem_sub;
  logic [DIV_STEPS:0]      quo_adj;
  logic signed [31:0]      quo_signed;
  logic signed [31:0]      bend_sum;
  logic [BEND_W-1:0]       bend_nxt;
  logic [BEND_W-1:0]       bend_r;

  // Message assembly.
  logic [7:0]        msg_status;
  logic [NOTE_W-1:0] msg_one;
  logic [NOTE_W-1:0] msg_two;
  logic              msg_last;

  ttm_ram #(.WIDTH(SID_W), .DEPTH(SLOTS), .AW(IDX_W)) u_sid_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata (sid_r),
    .raddr (idx_r),
    .rdata (rd_sid)
  );

  ttm_ram #(.WIDTH(NOTE_W), .DEPTH(SLOTS), .AW(IDX_W)) u_note_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata (note_r),
    .raddr (idx_r),
    .rdata (rd_note)
  );

  assign ram_we    = ctl.store_slot && free_r;
  assign cmp_valid = valid_r[cmp_idx_r];

  assign key = $signed({{2{bottom_r[KEY_W-1]}}, bottom_r})
             + $signed({2'b00, prod_r[31:16]});

  always_comb begin
    if (key[17]) begin
      note_on = '0;
    end else if (|key[16:15]) begin
      note_on = NOTE_MAX;
    end else begin
      note_on = key[14:8];
    end
  end

  assign diff     = $signed({key[17], key}) - $signed({4'b0000, note_r, 8'h00});
  assign diff_neg = 19'(-diff);
  assign mag      = diff[18] ? diff_neg[16:0] : diff[16:0];
  assign span_eff = (span_r == '0) ? KEY_W'(1) : span_r;

  assign rem_sh  = {rem_r, quo_r[DIV_STEPS-1]};
  assign rem_ge  = (rem_sh >= {1'b0, span_eff});
  assign rem_sub = rem_sh - {1'b0, span_eff};

  assign quo_adj    = {1'b0, quo_r} + (DIV_STEPS+1)'(neg_r && (rem_r != '0));
  assign quo_signed = neg_r ? -$signed(32'(quo_adj)) : $signed(32'(quo_adj));
  assign bend_sum   = quo_signed + BEND_CENTER;

  always_comb begin
    if (bend_sum < 0) begin
      bend_nxt = '0;
    end else if (bend_sum > BEND_MAX) begin
      bend_nxt = BEND_MAX[BEND_W-1:0];
    end else begin
      bend_nxt = bend_sum[BEND_W-1:0];
    end
  end

  assign eff_full = {y_r, 14'b0} - {14'b0, y_r};

  always_comb begin
    msg_last = 1'b0;
    unique case (ctl.emit_kind)
      MSG_ON: begin
        msg_status = STATUS_NOTE_ON;
        msg_one    = note_r;
        msg_two    = VELOCITY;
      end
      MSG_OFF: begin
        msg_status = STATUS_NOTE_OFF;
        msg_one    = note_r;
        msg_two    = VELOCITY;
        msg_last   = 1'b1;
      end
      MSG_BEND: begin
        msg_status = STATUS_BEND;
        msg_one    = bend_r[6:0];
        msg_two    = bend_r[13:7];
      end
      MSG_FINE: begin
        msg_status = STATUS_CTRL;
        msg_one    = ctrl_num_r | FINE_CTRL_BIT;
        msg_two    = eff_r[6:0];
      end
      MSG_COARSE: begin
        msg_status = STATUS_CTRL;
        msg_one    = ctrl_num_r;
        msg_two    = eff_r[13:7];
        msg_last   = 1'b1;
      end
      default: begin
        msg_status = STATUS_CTRL;
        msg_one    = ctrl_num_r;
        msg_two    = eff_r[13:7];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bottom_r   <= RST_BOTTOM_KEY;
      span_r     <= RST_KEY_SPAN;
      ctrl_num_r <= RST_CTRL_NUMBER;
      fine_r     <= RST_FINE_ENABLE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOTTOM_KEY:  bottom_r   <= cfg_data;
        CFG_KEY_SPAN:    span_r     <= cfg_data;
        CFG_CTRL_NUMBER: ctrl_num_r <= cfg_data[NOTE_W-1:0];
        CFG_FINE_ENABLE: fine_r     <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      idx_r      <= '0;
      cmp_v_r    <= 1'b0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      cmp_v_r    <= ctl.scan_rd;
      out_strobe <= ctl.emit;
      if (ctl.latch) begin
        idx_r  <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else begin
        if (ctl.scan_rd) begin
          idx_r <= idx_r + IDX_W'(1);
        end
        if (cmp_v_r && cmp_valid && (rd_sid == sid_r) && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (cmp_v_r && !cmp_valid && !free_r) begin
          free_r <= 1'b1;
        end
      end
      if (ram_we) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (ctl.free_slot) begin
        valid_r[hit_idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r  <= cmd_t'(in_cmd);
      sid_r  <= in_session_id;
      grp_r  <= in_group_id;
      time_r <= in_frame_time;
      x_r    <= in_pos_x;
      y_r    <= in_pos_y;
    end
    prod_r    <= {16'b0, x_r} * {16'b0, span_r};
    eff_r     <= eff_full[29:16];
    cmp_idx_r <= idx_r;
    if (cmp_v_r && cmp_valid && (rd_sid == sid_r) && !hit_r) begin
      hit_idx_r <= cmp_idx_r;
    end
    if (cmp_v_r && !cmp_valid && !free_r) begin
      free_idx_r <= cmp_idx_r;
    end
    if (ctl.load_note) begin
      note_r <= note_on;
    end else if (cmp_v_r && cmp_valid && (rd_sid == sid_r) && !hit_r) begin
      note_r <= rd_note;
    end
    if (ctl.div_init) begin
      quo_r <= {mag, BEND_SHIFT'(0)};
      rem_r <= '0;
      neg_r <= diff[18];
      cnt_r <= '0;
    end else if (ctl.div_step) begin
      quo_r <= {quo_r[DIV_STEPS-2:0], rem_ge};
      rem_r <= rem_ge ? rem_sub[KEY_W-1:0] : rem_sh[KEY_W-1:0];
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
    if (ctl.fix) begin
      bend_r <= bend_nxt;
    end
    if (ctl.emit) begin
      out_time         <= time_r;
      out_group        <= grp_r;
      out_status_byte  <= msg_status;
      out_data_one     <= msg_one;
      out_data_two     <= msg_two;
      out_last_message <= msg_last;
    end
  end

  assign st.cmd       = cmd_r;
  assign st.hit       = hit_r;
  assign st.scan_last = (idx_r == IDX_W'(SLOTS - 1));
  assign st.div_last  = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign st.fine_en   = fine_r;

  a_store_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !valid_r[free_idx_r])
    else $error("table write targets an occupied slot");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_message) |=> !out_strobe)
    else $error("message beat follows the last beat of an event");

endmodule

// ===== rtl/core/touch_to_midi_converter.sv =====
// Top level of the touch to MIDI converter.
// An event is taken when start is high and busy is low; busy then stays high until the event
// is finished. Each event first scans the SLOTS-entry session table, one entry per cycle
// through the table RAM's read port, and a touch-on or matched move then runs a one-bit-per-cycle
// divider of 30 steps for the pitch bend. A touch-on emits note-on, bend, fine controller
// (when enabled) and coarse controller messages, a matched move the same without note-on, a
// matched touch-off a note-off, and an unmatched or unused event no message.
// Message beats appear one per cycle on out_strobe, one cycle behind the sequencer, and must
// be taken as they come; the final beat of an event carries out_last_message. The table is
// empty after reset with no clearing pass.
module touch_to_midi_converter #(
  parameter int SLOTS = ttm_pkg::TTM_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ttm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ttm_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_cmd,
  input  logic [ttm_pkg::SID_W-1:0]       in_session_id,
  input  logic [ttm_pkg::GRP_W-1:0]       in_group_id,
  input  logic [ttm_pkg::TIME_W-1:0]      in_frame_time,
  input  logic [ttm_pkg::POS_W-1:0]       in_pos_x,
  input  logic [ttm_pkg::POS_W-1:0]       in_pos_y,
  output logic                            out_strobe,
  output logic [ttm_pkg::TIME_W-1:0]      out_time,
  output logic [ttm_pkg::GRP_W-1:0]       out_group,
  output logic [7:0]                      out_status_byte,
  output logic [ttm_pkg::NOTE_W-1:0]      out_data_one,
  output logic [ttm_pkg::NOTE_W-1:0]      out_data_two,
  output logic                            out_last_message
);
  import ttm_pkg::*;

  ctl_t ctl;
  sts_t st;

  ttm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .ctl   (ctl)
  );

  ttm_dp #(.SLOTS(SLOTS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .st               (st),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_cmd           (in_cmd),
    .in_session_id    (in_session_id),
    .in_group_id      (in_group_id),
    .in_frame_time    (in_frame_time),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .out_strobe       (out_strobe),
    .out_time         (out_time),
    .out_group        (out_group),
    .out_status_byte  (out_status_byte),
    .out_data_one     (out_data_one),
    .out_data_two     (out_data_two),
    .out_last_message (out_last_message)
  );

endmodule
